>>> sv/spq_pkg.sv
package spq_pkg;

  // Fixed widths of the payload fields on the ports
  localparam int unsigned OPCODE_FIELD_W   = 2;
  localparam int unsigned ID_FIELD_W       = 8;
  localparam int unsigned PRIORITY_FIELD_W = 8;
  localparam int unsigned COUNT_FIELD_W    = 5;
  localparam int unsigned STATUS_FIELD_W   = 2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_SERVE  = 2'd3
  } spq_op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_EMPTY   = 2'd3
  } spq_status_e;

  // What every cell of the chain does in a given cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_POP    = 2'd3
  } spq_cell_op_e;

  typedef struct packed {
    spq_cell_op_e op;
  } spq_cell_cmd_t;

  typedef struct packed {
    logic [OPCODE_FIELD_W-1:0]   opcode;
    logic [ID_FIELD_W-1:0]       entry_id;
    logic [PRIORITY_FIELD_W-1:0] priority_req;
  } spq_req_t;

  typedef struct packed {
    logic                        served_valid;
    logic [ID_FIELD_W-1:0]       served_id;
    logic [PRIORITY_FIELD_W-1:0] served_priority;
    logic [COUNT_FIELD_W-1:0]    entry_count;
    logic [STATUS_FIELD_W-1:0]   status;
  } spq_rsp_t;

endpackage

>>> sv/sorted_priority_queue.sv
// Bounded priority queue of QUEUE_DEPTH entries held in a row of cells in
// descending priority order, head in cell 0. Insert places the entry behind
// every stored entry of equal or higher priority (equal priorities leave in
// arrival order), remove deletes the first entry from the head with the given
// id, update is a remove followed by an insert, and serve pops the head. Each
// command returns one result beat with the entry count and a status. An update
// runs a remove pass and then an insert pass. The result is registered, and a
// new command is taken as long as no update is half done and the result
// register is free or being drained. Each cell compares priorities
// combinationally, and the found-above chain runs combinationally from the
// head through every cell.
// Ids and priorities are cut to ID_WIDTH and PRIORITY_WIDTH bits on entry.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH    = 16,
  parameter int unsigned ID_WIDTH       = 8,
  parameter int unsigned PRIORITY_WIDTH = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  spq_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output spq_rsp_t out_data_o
);

  localparam int unsigned CountW = $clog2(QUEUE_DEPTH + 1);

  // controller states
  localparam logic S_RUN = 1'b0;
  localparam logic S_UPD = 1'b1;

  logic                      state_q, state_d;
  logic [CountW-1:0]         count_q, count_d;
  logic [ID_WIDTH-1:0]       upd_id_q, upd_id_d;
  logic [PRIORITY_WIDTH-1:0] upd_prio_q, upd_prio_d;
  logic                      upd_found_q, upd_found_d;
  logic                      out_valid_q, out_valid_d;
  spq_rsp_t                  out_data_q, out_data_d;

  logic                      in_fire, out_write, full, empty, found_all;
  logic [ID_WIDTH-1:0]       in_id, key_id;
  logic [PRIORITY_WIDTH-1:0] in_prio, key_prio;
  spq_cell_cmd_t             cell_cmd;

  logic [QUEUE_DEPTH-1:0]    valid_w, ge_w, found_w;
  logic [ID_WIDTH-1:0]       id_w   [QUEUE_DEPTH];
  logic [PRIORITY_WIDTH-1:0] prio_w [QUEUE_DEPTH];

  assign in_id   = ID_WIDTH'(in_data_i.entry_id);
  assign in_prio = PRIORITY_WIDTH'(in_data_i.priority_req);

  // Take a command only while no update is half done and the result slot
  // is free or being emptied this cycle
  assign in_ready_o = (state_q == S_RUN) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  assign full      = (count_q == CountW'(QUEUE_DEPTH));
  assign empty     = (count_q == '0);
  assign found_all = found_w[QUEUE_DEPTH-1];

  // The second pass of an update uses the key held from the first pass
  assign key_id   = (state_q == S_UPD) ? upd_id_q : in_id;
  assign key_prio = (state_q == S_UPD) ? upd_prio_q : in_prio;

  // ---------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------
  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    logic                      up_valid, up_ge, up_found, dn_valid;
    logic [ID_WIDTH-1:0]       up_id, dn_id;
    logic [PRIORITY_WIDTH-1:0] up_prio, dn_prio;

    if (gi == 0) begin : g_head
      // Nothing above the head: an insert that reaches it lands here
      assign up_valid = 1'b0;
      assign up_id    = '0;
      assign up_prio  = '0;
      assign up_ge    = 1'b1;
      assign up_found = 1'b0;
    end else begin : g_up
      assign up_valid = valid_w[gi-1];
      assign up_id    = id_w[gi-1];
      assign up_prio  = prio_w[gi-1];
      assign up_ge    = ge_w[gi-1];
      assign up_found = found_w[gi-1];
    end

    if (gi == QUEUE_DEPTH - 1) begin : g_tail
      // Shifting towards the head pulls an empty slot in at the tail
      assign dn_valid = 1'b0;
      assign dn_id    = '0;
      assign dn_prio  = '0;
    end else begin : g_dn
      assign dn_valid = valid_w[gi+1];
      assign dn_id    = id_w[gi+1];
      assign dn_prio  = prio_w[gi+1];
    end

    spq_cell #(
      .ID_WIDTH       (ID_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cell_cmd),
      .key_id_i   (key_id),
      .key_prio_i (key_prio),
      .up_valid_i (up_valid),
      .up_id_i    (up_id),
      .up_prio_i  (up_prio),
      .up_ge_i    (up_ge),
      .up_found_i (up_found),
      .dn_valid_i (dn_valid),
      .dn_id_i    (dn_id),
      .dn_prio_i  (dn_prio),
      .valid_o    (valid_w[gi]),
      .id_o       (id_w[gi]),
      .prio_o     (prio_w[gi]),
      .ge_o       (ge_w[gi]),
      .found_o    (found_w[gi])
    );
  end

  // ---------------------------------------------------------------------
  // Controller
  // ---------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    upd_id_d    = upd_id_q;
    upd_prio_d  = upd_prio_q;
    upd_found_d = upd_found_q;
    cell_cmd.op = CELL_HOLD;
    out_write   = 1'b0;
    out_data_d  = out_data_q;

    if (state_q == S_UPD) begin
      // Insert half of an update; drop it when the queue is full
      out_write                  = 1'b1;
      out_data_d.served_valid    = 1'b0;
      out_data_d.served_id       = '0;
      out_data_d.served_priority = '0;
      if (full) begin
        out_data_d.status = ST_FULL;
      end else begin
        cell_cmd.op = CELL_INSERT;
        count_d     = count_q + CountW'(1);
        out_data_d.status = upd_found_q ? ST_DONE : ST_MISSING;
      end
      state_d = S_RUN;
    end else if (in_fire) begin
      out_data_d.served_valid    = 1'b0;
      out_data_d.served_id       = '0;
      out_data_d.served_priority = '0;
      out_data_d.status          = ST_DONE;
      case (in_data_i.opcode)
        OP_INSERT: begin
          out_write = 1'b1;
          if (full) begin
            out_data_d.status = ST_FULL;
          end else begin
            cell_cmd.op = CELL_INSERT;
            count_d     = count_q + CountW'(1);
          end
        end
        OP_REMOVE: begin
          out_write   = 1'b1;
          cell_cmd.op = CELL_REMOVE;
          if (found_all) begin
            count_d = count_q - CountW'(1);
          end else begin
            out_data_d.status = ST_MISSING;
          end
        end
        OP_UPDATE: begin
          // Remove pass now, hold the key for the insert pass
          cell_cmd.op = CELL_REMOVE;
          if (found_all) begin
            count_d = count_q - CountW'(1);
          end
          upd_id_d    = in_id;
          upd_prio_d  = in_prio;
          upd_found_d = found_all;
          state_d     = S_UPD;
        end
        default: begin
          // serve head
          out_write = 1'b1;
          if (empty) begin
            out_data_d.status = ST_EMPTY;
          end else begin
            cell_cmd.op                = CELL_POP;
            count_d                    = count_q - CountW'(1);
            out_data_d.served_valid    = 1'b1;
            out_data_d.served_id       = ID_FIELD_W'(id_w[0]);
            out_data_d.served_priority = PRIORITY_FIELD_W'(prio_w[0]);
          end
        end
      endcase
    end

    if (out_write) begin
      out_data_d.entry_count = COUNT_FIELD_W'(count_d);
    end

    out_valid_d = out_write ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    upd_id_q    <= upd_id_d;
    upd_prio_q  <= upd_prio_d;
    upd_found_q <= upd_found_d;
    out_data_q  <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_w) == int'(count_q))
    else $error("entry count differs from occupied cells");

  a_prefix_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> valid_w[0])
    else $error("occupied cells do not start at the head");

  a_update_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (!out_valid_q && !in_ready_o) ##1 (state_q == S_RUN))
    else $error("update insert pass misbehaved");

  a_served_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.served_valid) |-> (out_data_o.status == ST_DONE))
    else $error("served beat with failing status");
`endif

endmodule

>>> sv/spq_cell.sv
module spq_cell import spq_pkg::*; #(
  parameter int unsigned ID_WIDTH       = 8,
  parameter int unsigned PRIORITY_WIDTH = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spq_cell_cmd_t             cmd_i,
  input  logic [ID_WIDTH-1:0]       key_id_i,
  input  logic [PRIORITY_WIDTH-1:0] key_prio_i,
  // neighbour towards the head
  input  logic                      up_valid_i,
  input  logic [ID_WIDTH-1:0]       up_id_i,
  input  logic [PRIORITY_WIDTH-1:0] up_prio_i,
  input  logic                      up_ge_i,
  input  logic                      up_found_i,
  // neighbour towards the tail
  input  logic                      dn_valid_i,
  input  logic [ID_WIDTH-1:0]       dn_id_i,
  input  logic [PRIORITY_WIDTH-1:0] dn_prio_i,
  output logic                      valid_o,
  output logic [ID_WIDTH-1:0]       id_o,
  output logic [PRIORITY_WIDTH-1:0] prio_o,
  output logic                      ge_o,
  output logic                      found_o
);

  logic                      valid_q, valid_d;
  logic [ID_WIDTH-1:0]       id_q, id_d;
  logic [PRIORITY_WIDTH-1:0] prio_q, prio_d;
  logic                      ge, hit;

  assign ge      = valid_q && (prio_q >= key_prio_i);
  assign hit     = valid_q && (id_q == key_id_i);
  assign found_o = up_found_i | hit;

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    prio_d  = prio_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        if (!ge) begin
          if (up_ge_i) begin
            valid_d = 1'b1;
            id_d    = key_id_i;
            prio_d  = key_prio_i;
          end else begin
            valid_d = up_valid_i;
            id_d    = up_id_i;
            prio_d  = up_prio_i;
          end
        end
      end
      CELL_REMOVE: begin
        if (up_found_i || hit) begin
          valid_d = dn_valid_i;
          id_d    = dn_id_i;
          prio_d  = dn_prio_i;
        end
      end
      CELL_POP: begin
        valid_d = dn_valid_i;
        id_d    = dn_id_i;
        prio_d  = dn_prio_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    prio_q <= prio_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign prio_o  = prio_q;
  assign ge_o    = ge;

endmodule
